// ----- rtl/core/sbpe_pkg.sv -----
`default_nettype none

package sbpe_pkg;

    // Input commands.
    typedef enum logic [1:0] {
        CMD_WR_POS   = 2'd0,
        CMD_WR_SPEED = 2'd1,
        CMD_RD_POS   = 2'd2,
        CMD_RX_BYTE  = 2'd3
    } t_cmd;

    // Reply status codes.
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_CHK_ERR = 2'd1;
    localparam logic [1:0] STAT_ID_ERR  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_GOAL_POS    = 2'd0;
    localparam logic [1:0] REG_SPEED       = 2'd1;
    localparam logic [1:0] REG_PRESENT_POS = 2'd2;

    // Configuration reset values.
    localparam logic [7:0] GOAL_POS_RST    = 8'h2A;
    localparam logic [7:0] SPEED_RST       = 8'h2E;
    localparam logic [7:0] PRESENT_POS_RST = 8'h38;

    // Frame constants.
    localparam logic [7:0] SYNC_BYTE     = 8'hFF;
    localparam logic [7:0] LEN_WRITE     = 8'h05;
    localparam logic [7:0] OP_WRITE      = 8'h03;
    localparam logic [7:0] LEN_READ      = 8'h04;
    localparam logic [7:0] OP_READ       = 8'h02;
    localparam logic [7:0] READ_NBYTES   = 8'h02;
    localparam logic [3:0] WR_FRAME_LEN  = 4'd9;
    localparam logic [3:0] RD_FRAME_LEN  = 4'd8;
    localparam logic [3:0] RPL_FRAME_LEN = 4'd1;

    // Receiver positions inside a reply.
    localparam logic [2:0] RX_POS_ID   = 3'd2;
    localparam logic [2:0] RX_POS_HI   = 3'd5;
    localparam logic [2:0] RX_POS_LO   = 3'd6;
    localparam logic [2:0] RX_POS_CHK  = 3'd7;
    localparam logic [2:0] RX_POS_SYNC = 3'd2;

    typedef struct packed {
        logic        valid;
        logic [1:0]  status;
        logic [15:0] position;
    } t_reply;

    typedef struct packed {
        logic [8:0][7:0] bytes;
        logic [3:0]      len;
        logic            reply;
        logic [1:0]      status;
        logic [15:0]     position;
    } t_frame;

    // Builds the outgoing command frame; byte 0 is sent first.
    function automatic t_frame build_frame(input t_cmd cmd, input logic [7:0] id,
                                           input logic [15:0] val,
                                           input logic [7:0] addr);
        t_frame     f;
        logic [7:0] sum;
        f = '0;
        f.bytes[0] = SYNC_BYTE;
        f.bytes[1] = SYNC_BYTE;
        f.bytes[2] = id;
        f.bytes[5] = addr;
        if (cmd == CMD_RD_POS) begin
            f.bytes[3] = LEN_READ;
            f.bytes[4] = OP_READ;
            f.bytes[6] = READ_NBYTES;
            sum = id + LEN_READ + OP_READ + addr + READ_NBYTES;
            f.bytes[7] = ~sum;
            f.len = RD_FRAME_LEN;
        end else begin
            f.bytes[3] = LEN_WRITE;
            f.bytes[4] = OP_WRITE;
            f.bytes[6] = val[15:8];
            f.bytes[7] = val[7:0];
            sum = id + LEN_WRITE + OP_WRITE + addr + val[15:8] + val[7:0];
            f.bytes[8] = ~sum;
            f.len = WR_FRAME_LEN;
        end
        return f;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sbpe_if.sv -----
`default_nettype none

interface sbpe_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [7:0]  servo_id;
    logic [15:0] value;
    logic [7:0]  rx_byte;

    modport source (output valid, command, servo_id, value, rx_byte, input ready);
    modport sink   (input valid, command, servo_id, value, rx_byte, output ready);
endinterface

interface sbpe_out_if;
    logic        valid;
    logic        ready;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        frame_end;
    logic        reply_valid;
    logic [1:0]  reply_status;
    logic [15:0] reply_position;

    modport source (output valid, tx_valid, tx_byte, frame_end, reply_valid,
                    reply_status, reply_position, input ready);
    modport sink   (input valid, tx_valid, tx_byte, frame_end, reply_valid,
                    reply_status, reply_position, output ready);
endinterface

interface sbpe_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sbpe_rx.sv -----
`default_nettype none

module sbpe_rx
    import sbpe_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [1:0] i_command,
    input  wire logic [7:0] i_servo_id,
    input  wire logic [7:0] i_rx_byte,
    output t_reply          o_reply
);

    logic [2:0] r_count, n_count;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_exp_id, n_exp_id;
    logic [7:0] r_id, n_id;
    logic [7:0] r_hi, n_hi;
    logic [7:0] r_lo, n_lo;

    always_comb begin
        n_count  = r_count;
        n_sum    = r_sum;
        n_exp_id = r_exp_id;
        n_id     = r_id;
        n_hi     = r_hi;
        n_lo     = r_lo;
        o_reply  = '0;
        if (i_accept) begin
            unique case (t_cmd'(i_command))
                CMD_RD_POS: begin
                    n_count  = '0;
                    n_sum    = '0;
                    n_exp_id = i_servo_id;
                end
                CMD_RX_BYTE: begin
                    if (r_count < RX_POS_SYNC) begin
                        // Hunting for the two sync bytes.
                        if (i_rx_byte == SYNC_BYTE) begin
                            n_count = r_count + 3'd1;
                            if (n_count == RX_POS_SYNC) begin
                                n_sum = '0;
                            end
                        end else begin
                            n_count = '0;
                        end
                    end else if (r_count != RX_POS_CHK) begin
                        if (r_count == RX_POS_ID) n_id = i_rx_byte;
                        if (r_count == RX_POS_HI) n_hi = i_rx_byte;
                        if (r_count == RX_POS_LO) n_lo = i_rx_byte;
                        n_sum   = r_sum + i_rx_byte;
                        n_count = r_count + 3'd1;
                    end else begin
                        o_reply.valid = 1'b1;
                        if (r_id != r_exp_id) begin
                            o_reply.status = STAT_ID_ERR;
                        end else if (i_rx_byte != ~r_sum) begin
                            o_reply.status = STAT_CHK_ERR;
                        end else begin
                            o_reply.status   = STAT_OK;
                            o_reply.position = {r_hi, r_lo};
                        end
                        n_count = '0;
                        n_sum   = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_sum    <= '0;
            r_exp_id <= '0;
        end else begin
            r_count  <= n_count;
            r_sum    <= n_sum;
            r_exp_id <= n_exp_id;
        end
        r_id <= n_id;
        r_hi <= n_hi;
        r_lo <= n_lo;
    end

    a_reply_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_reply.valid |-> i_accept && i_command == CMD_RX_BYTE && r_count == RX_POS_CHK)
        else $error("reply judged outside the checksum byte");
    a_reply_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_reply.valid |=> r_count == 3'd0 && r_sum == 8'd0)
        else $error("receiver not rearmed after a reply");
    a_read_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_command == CMD_RD_POS |=> r_count == 3'd0 && r_exp_id == $past(i_servo_id))
        else $error("read request did not reset the receiver");

endmodule

`default_nettype wire

// ----- rtl/core/sbpe_ser.sv -----
`default_nettype none

module sbpe_ser
    import sbpe_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_frame  i_frame,
    output logic         o_can_load,
    sbpe_out_if.source   o_out
);

    logic            r_busy;
    logic [3:0]      r_left;
    logic [8:0][7:0] r_bytes;
    logic            r_reply;
    logic [1:0]      r_status;
    logic [15:0]     r_pos;
    logic            w_adv;
    logic            w_last;

    assign w_last     = (r_left == 4'd1);
    assign w_adv      = r_busy && o_out.ready;
    assign o_can_load = !r_busy || (w_adv && w_last);

    assign o_out.valid          = r_busy;
    assign o_out.tx_valid       = !r_reply;
    assign o_out.tx_byte        = r_reply ? 8'h00 : r_bytes[0];
    assign o_out.frame_end      = w_last;
    assign o_out.reply_valid    = r_reply;
    assign o_out.reply_status   = r_status;
    assign o_out.reply_position = r_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_left <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_left <= i_frame.len;
        end else if (w_adv) begin
            r_busy <= !w_last;
            r_left <= r_left - 4'd1;
        end
        if (i_load) begin
            r_bytes  <= i_frame.bytes;
            r_reply  <= i_frame.reply;
            r_status <= i_frame.status;
            r_pos    <= i_frame.position;
        end else if (w_adv) begin
            r_bytes <= {8'h00, r_bytes[8:1]};
        end
    end

    a_load_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_can_load)
        else $error("frame loaded over one still being sent");
    a_left_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_left != 4'd0)
        else $error("busy with nothing left to send");
    a_reply_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_reply |-> r_left == 4'd1)
        else $error("reply result longer than one item");

endmodule

`default_nettype wire

// ----- rtl/core/servo_bus_packet_engine.sv -----
`default_nettype none

// Servo bus packet engine.
// Requests enter on i_in. A write-position or write-speed request produces a
// nine-result write frame, a read-position request produces an eight-result
// read frame and rearms the reply receiver, and a received-byte request is fed
// to the reply receiver, which gives one result when a complete reply has been
// judged and none otherwise.
// Results leave on o_out, one per cycle while the receiver takes them; the
// last result of each request carries frame_end.
// A request is turned into a whole frame in the cycle it is accepted and
// loaded into the output shift register, so the first result appears in the
// cycle after acceptance. That shift register paces the output: a write gives
// nine results, a read eight and a judged reply one; a received byte that
// gives no result loads nothing. A new request is taken while the last
// result of the previous one is being handed over, so frames follow
// without a gap. When the receiver stalls, the current result holds and
// i_in.ready stays low until the final result of the frame goes out.
// Configuration writes on i_cfg are always taken; index 3 is ignored.
// Reset is synchronous: the receiver goes back to hunting for sync, the
// expected reply id clears to zero, the register addresses return to 42, 46
// and 56, and any frame in flight is dropped.

module servo_bus_packet_engine
    import sbpe_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sbpe_in_if.sink    i_in,
    sbpe_out_if.source o_out,
    sbpe_cfg_if.sink   i_cfg
);

    logic [7:0] r_goal_reg;
    logic [7:0] r_speed_reg;
    logic [7:0] r_present_reg;

    logic       w_accept;
    logic       w_can_load;
    logic       w_load;
    logic [7:0] w_addr;
    t_reply     w_reply;
    t_frame     w_frame;

    // Configuration registers; the port never stalls.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_reg    <= GOAL_POS_RST;
            r_speed_reg   <= SPEED_RST;
            r_present_reg <= PRESENT_POS_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_GOAL_POS:    r_goal_reg    <= i_cfg.data;
                REG_SPEED:       r_speed_reg   <= i_cfg.data;
                REG_PRESENT_POS: r_present_reg <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    assign i_in.ready = w_can_load;
    assign w_accept   = i_in.valid && i_in.ready;

    sbpe_rx u_rx (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_command  (i_in.command),
        .i_servo_id (i_in.servo_id),
        .i_rx_byte  (i_in.rx_byte),
        .o_reply    (w_reply)
    );

    // Pick the register address that goes into the outgoing frame.
    always_comb begin
        case (t_cmd'(i_in.command))
            CMD_WR_POS:   w_addr = r_goal_reg;
            CMD_WR_SPEED: w_addr = r_speed_reg;
            default:      w_addr = r_present_reg;
        endcase
    end

    // A received byte only loads a result when it completes a reply.
    always_comb begin
        if (i_in.command == CMD_RX_BYTE) begin
            w_frame          = '0;
            w_frame.len      = RPL_FRAME_LEN;
            w_frame.reply    = 1'b1;
            w_frame.status   = w_reply.status;
            w_frame.position = w_reply.position;
            w_load           = w_accept && w_reply.valid;
        end else begin
            w_frame = build_frame(t_cmd'(i_in.command), i_in.servo_id, i_in.value, w_addr);
            w_load  = w_accept;
        end
    end

    sbpe_ser u_ser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_frame    (w_frame),
        .o_can_load (w_can_load),
        .o_out      (o_out)
    );

    a_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && o_out.valid |-> o_out.ready && o_out.frame_end)
        else $error("request accepted in the middle of a frame");
    a_cmd_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_in.command != CMD_RX_BYTE |=> o_out.valid && o_out.tx_valid)
        else $error("command request did not start a frame");
    a_tx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.tx_valid |-> !o_out.reply_valid && o_out.reply_position == 16'd0)
        else $error("transmit result carries reply fields");

endmodule

`default_nettype wire
